@@ rtl/core/spsum_pkg.sv @@
// Shared types, constants and arithmetic helpers of the spectral probability sum.
package spsum_pkg;

   // Operation codes carried by an input item
   typedef enum logic [1:0] {
      FUNC_EIGENVALUE = 2'd0,
      FUNC_VECTOR     = 2'd1,
      FUNC_INVERSE    = 2'd2,
      FUNC_QUERY      = 2'd3
   } func_type;

   // Register indexes of the configuration port
   typedef enum logic {
      CSR_STATE_COUNT = 1'b0,
      CSR_UNUSED      = 1'b1
   } csr_index_type;

   localparam int          MAX_STATES_DEFAULT = 64;
   localparam logic [6:0]  STATE_COUNT_RESET  = 7'd64;

   // Fixed-point constants of the exponential
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic write;   // store the item's value
      logic load;    // latch query operands, clear the accumulator
      logic zero;    // answer the query with zero
      logic issue;   // read one eigenpair and start its term
      logic last;    // the issued eigenpair closes the sum
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic done;    // last term accumulated, result goes out
   } dp_status_type;

   // Magnitude of a two's complement word
   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

   // 2^(q/4) in Q.30
   function automatic logic [30:0] quarter_pow(input logic [1:0] q);
      case (q)
         2'd0:    quarter_pow = 31'd1073741824;
         2'd1:    quarter_pow = 31'd1276901417;
         2'd2:    quarter_pow = 31'd1518500250;
         default: quarter_pow = 31'd1805811301;
      endcase
   endfunction

   // ceil(2^34 / k): exact quotient for dividends below 2^31 after >> 34
   function automatic logic [34:0] recip(input logic [2:0] k);
      case (k)
         3'd1:    recip = 35'd17179869184;
         3'd2:    recip = 35'd8589934592;
         3'd3:    recip = 35'd5726623062;
         3'd4:    recip = 35'd4294967296;
         3'd5:    recip = 35'd3435973837;
         3'd6:    recip = 35'd2863311531;
         3'd7:    recip = 35'd2454267027;
         default: recip = 35'd0;
      endcase
   endfunction

endpackage

@@ rtl/core/spectral_probability_sum.sv @@
// Top level: configuration register, controller, datapath and checks.
//
// Write items (eigenvalue, eigenvector entry, inverse entry) leave busy low,
// so a new item may follow in the next cycle. A query over N eigenpairs
// (N = state_count, capped at MAX_STATES) raises busy, reads one eigenpair
// per cycle from the stores and streams its term through a 21-stage
// exponential pipeline and a 5-stage product and clip pipeline into a
// saturating accumulator; busy drops in the cycle of the result strobe. A
// query whose indexes lie beyond the store or with state_count zero answers
// zero in the cycle after it is taken. The result is shown for exactly one
// cycle and must be captured then. Stores hold no reset value: entries never
// written read as anything.
module spectral_probability_sum import spsum_pkg::*; #(
   parameter int MAX_STATES = MAX_STATES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [5:0]         req_row_index,
   input  logic [5:0]         req_col_index,
   input  logic signed [31:0] req_value,
   input  logic [47:0]        req_timepoint,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_probability,
   output logic               rsp_saturated,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [6:0]                    state_count_ff;
   ctrl_cmd_type                  cmd;
   dp_status_type                 status;
   logic [$clog2(MAX_STATES)-1:0] idx;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff <= STATE_COUNT_RESET;
      end else if (psel && penable && pwrite && pready
                   && (csr_index_type'(paddr[2]) == CSR_STATE_COUNT)) begin
         state_count_ff <= pwdata[6:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (csr_index_type'(paddr[2]) == CSR_STATE_COUNT)
                   ? {25'd0, state_count_ff} : 32'd0;

   spsum_ctrl #(
      .MAX_STATES (MAX_STATES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_func      (req_func),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .state_count   (state_count_ff),
      .status        (status),
      .busy          (busy),
      .cmd           (cmd),
      .idx           (idx)
   );

   spsum_dp #(
      .MAX_STATES (MAX_STATES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .idx             (idx),
      .status          (status),
      .req_func        (req_func),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_value       (req_value),
      .req_timepoint   (req_timepoint),
      .rsp_strobe      (rsp_strobe),
      .rsp_probability (rsp_probability),
      .rsp_saturated   (rsp_saturated)
   );

   // Busy rises only after an item is taken
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a taken item");

   // A result never shows while a query is still running
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // Finishing a query always delivers its result
   a_fall_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("query ended without a result");

endmodule

@@ rtl/core/spsum_exp.sv @@
// Pipelined exp(eigenvalue * time) in unsigned Q16.48, with a side-band line.
module spsum_exp import spsum_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [31:0]       in_ev,
   input  logic [47:0]       in_time,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [63:0]       out_exp,
   output logic [SIDE_W-1:0] out_side
);

   localparam int LAT = 21;

   logic [LAT-1:0]    vld_ff;
   logic [SIDE_W-1:0] side_ff [LAT];

   logic [31:0] mev;
   logic [55:0] hp1_ff, lp1_ff;
   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [56:0] lim2, sum2, p2;
   logic [21:0] x16_ff;
   logic [38:0] my3_ff;
   logic [39:0] b4;
   logic signed [7:0] n4_ff, n5_ff, n20_ff;
   logic [31:0] f4_ff;
   logic [29:0] u5_ff;
   logic [1:0]  q5_ff;

   logic [32:0]       acc_in [8];
   logic [29:0]       u_in   [8];
   logic signed [7:0] n_in   [8];
   logic [1:0]        q_in   [8];
   logic [30:0]       pr_ff  [7];
   logic [32:0]       acc_ff [7];
   logic [29:0]       ua_ff  [7];
   logic [29:0]       ub_ff  [7];
   logic signed [7:0] na_ff  [7];
   logic signed [7:0] nb_ff  [7];
   logic [1:0]        qa_ff  [7];
   logic [1:0]        qb_ff  [7];

   logic [33:0]       mres_ff;
   logic signed [7:0] sh;
   logic [7:0]        rsh;
   logic [4:0]        lsh;
   logic [63:0]       exp_ff;

   // Advance valid flags and side band alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int j = 1; j < LAT; j++) begin
         side_ff[j] <= side_ff[j-1];
      end
   end

   // Stage 1: magnitude times the two halves of the time
   assign mev = mag32(in_ev);

   always_ff @(posedge clock) begin
      hp1_ff  <= 56'(mev) * 56'(in_time[47:24]);
      lp1_ff  <= 56'(mev) * 56'(in_time[23:0]);
      neg1_ff <= in_ev[31];
   end

   // Stage 2: clamp the exact Q.32 argument, keep Q.16
   always_comb begin
      lim2 = neg1_ff ? (57'd32 << 32) : (57'd8 << 32);
      sum2 = 57'({hp1_ff[13:0], 24'd0}) + 57'(lp1_ff);
      if (hp1_ff >= 56'd16384) begin
         p2 = lim2;
      end else if (sum2 > lim2) begin
         p2 = lim2;
      end else begin
         p2 = sum2;
      end
   end

   always_ff @(posedge clock) begin
      x16_ff  <= p2[37:16];
      neg2_ff <= neg1_ff;
   end

   // Stage 3: scale by log2(e)
   always_ff @(posedge clock) begin
      my3_ff  <= 39'((53'(x16_ff) * 53'(LOG2E_Q30)) >> 14);
      neg3_ff <= neg2_ff;
   end

   // Stage 4: split into integer and fraction
   assign b4 = neg3_ff ? ((40'd64 << 32) - 40'(my3_ff)) : ((40'd64 << 32) + 40'(my3_ff));

   always_ff @(posedge clock) begin
      n4_ff <= $signed(b4[39:32]) - 8'sd64;
      f4_ff <= b4[31:0];
   end

   // Stage 5: residual fraction times ln2
   always_ff @(posedge clock) begin
      u5_ff <= 30'((62'(f4_ff[29:0]) * 62'(LN2_Q32)) >> 32);
      q5_ff <= f4_ff[31:30];
      n5_ff <= n4_ff;
   end

   // Horner steps, k from 7 down to 1, two stages each
   assign acc_in[0] = ONE_Q32;
   assign u_in[0]   = u5_ff;
   assign n_in[0]   = n5_ff;
   assign q_in[0]   = q5_ff;

   for (genvar j = 0; j < 7; j++) begin : g_horner
      always_ff @(posedge clock) begin
         pr_ff[j]  <= 31'((63'(acc_in[j]) * 63'(u_in[j])) >> 32);
         ua_ff[j]  <= u_in[j];
         na_ff[j]  <= n_in[j];
         qa_ff[j]  <= q_in[j];
         acc_ff[j] <= ONE_Q32
                      + 33'((66'(pr_ff[j]) * 66'(recip(3'(7 - j)))) >> 34);
         ub_ff[j]  <= ua_ff[j];
         nb_ff[j]  <= na_ff[j];
         qb_ff[j]  <= qa_ff[j];
      end
      assign acc_in[j+1] = acc_ff[j];
      assign u_in[j+1]   = ub_ff[j];
      assign n_in[j+1]   = nb_ff[j];
      assign q_in[j+1]   = qb_ff[j];
   end

   // Stage 20: apply the quarter-power table
   always_ff @(posedge clock) begin
      mres_ff <= 34'((64'(acc_in[7]) * 64'(quarter_pow(q_in[7]))) >> 30);
      n20_ff  <= n_in[7];
   end

   // Stage 21: scale by 2^n into Q16.48
   always_comb begin
      sh  = n20_ff + 8'sd16;
      rsh = 8'(-sh);
      lsh = (sh > 8'sd27) ? 5'd27 : sh[4:0];
   end

   always_ff @(posedge clock) begin
      if (sh >= 8'sd0) begin
         exp_ff <= 64'(mres_ff) << lsh;
      end else if (rsh > 8'd63) begin
         exp_ff <= 64'd0;
      end else begin
         exp_ff <= 64'(mres_ff) >> rsh[5:0];
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_exp   = exp_ff;
   assign out_side  = side_ff[LAT-1];

endmodule

@@ rtl/core/spsum_dp.sv @@
// Datapath: eigensystem stores, term pipeline and saturating accumulator.
module spsum_dp import spsum_pkg::*; #(
   parameter int MAX_STATES = MAX_STATES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_cmd_type                  cmd,
   input  logic [$clog2(MAX_STATES)-1:0] idx,
   output dp_status_type                 status,
   input  logic [1:0]                    req_func,
   input  logic [5:0]                    req_row_index,
   input  logic [5:0]                    req_col_index,
   input  logic signed [31:0]            req_value,
   input  logic [47:0]                   req_timepoint,
   output logic                          rsp_strobe,
   output logic signed [31:0]            rsp_probability,
   output logic                          rsp_saturated
);

   localparam int AW = $clog2(MAX_STATES);
   localparam int MA = $clog2(MAX_STATES * MAX_STATES);

   logic [31:0] ev_mem  [MAX_STATES];
   logic [31:0] vec_mem [MAX_STATES * MAX_STATES];
   logic [31:0] inv_mem [MAX_STATES * MAX_STATES];

   logic          wr_ok, ev_we, vec_we, inv_we;
   logic [MA-1:0] wr_addr, vec_raddr, inv_raddr;
   logic [5:0]    row_ff, col_ff;
   logic [47:0]   time_ff;
   logic [31:0]   ev_rd_ff, vec_rd_ff, inv_rd_ff;
   logic          v0_ff, l0_ff;

   logic          ex_valid;
   logic [63:0]   ex_val;
   logic [64:0]   ex_side;

   logic          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic          l1_ff, l2_ff, l3_ff, l4_ff, l5_ff;
   logic          n1_ff, n2_ff, n3_ff, n4_ff;
   logic [63:0]   a1_ff, e1_ff;
   logic [63:0]   pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [33:0]   mid3_ff;
   logic [63:0]   p11_3_ff;
   logic [31:0]   p01h_ff, p10h_ff;
   logic [63:0]   hi4;
   logic [61:0]   mag4_ff;
   logic signed [31:0] term5_ff;
   logic          tsat5_ff;

   logic signed [31:0] acc_ff;
   logic          sat_ff;
   logic signed [33:0] sum;
   logic signed [31:0] sum_clip;
   logic          sum_sat;
   logic          rsp_strobe_ff, rsp_sat_ff;
   logic signed [31:0] rsp_prob_ff;

   // Decode writes; drop those beyond the store
   always_comb begin
      wr_ok     = (32'(req_row_index) < 32'(MAX_STATES))
                  && (32'(req_col_index) < 32'(MAX_STATES));
      ev_we     = cmd.write && wr_ok && (func_type'(req_func) == FUNC_EIGENVALUE);
      vec_we    = cmd.write && wr_ok && (func_type'(req_func) == FUNC_VECTOR);
      inv_we    = cmd.write && wr_ok && (func_type'(req_func) == FUNC_INVERSE);
      wr_addr   = MA'(req_row_index) * MA'(MAX_STATES) + MA'(req_col_index);
      vec_raddr = MA'(row_ff) * MA'(MAX_STATES) + MA'(idx);
      inv_raddr = MA'(idx) * MA'(MAX_STATES) + MA'(col_ff);
   end

   // Stores: one write port, registered read
   always_ff @(posedge clock) begin
      if (ev_we) begin
         ev_mem[AW'(req_row_index)] <= req_value;
      end
      ev_rd_ff <= ev_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[wr_addr] <= req_value;
      end
      vec_rd_ff <= vec_mem[vec_raddr];
   end

   always_ff @(posedge clock) begin
      if (inv_we) begin
         inv_mem[wr_addr] <= req_value;
      end
      inv_rd_ff <= inv_mem[inv_raddr];
   end

   // Hold query operands
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff  <= req_row_index;
         col_ff  <= req_col_index;
         time_ff <= req_timepoint;
      end
   end

   // Valid flags of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v0_ff <= cmd.issue;
         v1_ff <= ex_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   spsum_exp #(
      .SIDE_W (65)
   ) u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_ev     (ev_rd_ff),
      .in_time   (time_ff),
      .in_side   ({l0_ff, vec_rd_ff, inv_rd_ff}),
      .out_valid (ex_valid),
      .out_exp   (ex_val),
      .out_side  (ex_side)
   );

   // Product of vector and inverse magnitudes, partial products, reduction
   always_ff @(posedge clock) begin
      l0_ff    <= cmd.last;
      a1_ff    <= 64'(mag32(ex_side[63:32])) * 64'(mag32(ex_side[31:0]));
      n1_ff    <= ex_side[63] ^ ex_side[31];
      e1_ff    <= ex_val;
      l1_ff    <= ex_side[64];

      pp00_ff  <= 64'(a1_ff[31:0])  * 64'(e1_ff[31:0]);
      pp01_ff  <= 64'(a1_ff[31:0])  * 64'(e1_ff[63:32]);
      pp10_ff  <= 64'(a1_ff[63:32]) * 64'(e1_ff[31:0]);
      pp11_ff  <= 64'(a1_ff[63:32]) * 64'(e1_ff[63:32]);
      n2_ff    <= n1_ff;
      l2_ff    <= l1_ff;

      mid3_ff  <= 34'(pp00_ff[63:32]) + 34'(pp01_ff[31:0]) + 34'(pp10_ff[31:0]);
      p11_3_ff <= pp11_ff;
      p01h_ff  <= pp01_ff[63:32];
      p10h_ff  <= pp10_ff[63:32];
      n3_ff    <= n2_ff;
      l3_ff    <= l2_ff;

      mag4_ff  <= hi4[63:2];
      n4_ff    <= n3_ff;
      l4_ff    <= l3_ff;

      l5_ff    <= l4_ff;
   end

   assign hi4 = p11_3_ff + 64'(p01h_ff) + 64'(p10h_ff) + 64'(mid3_ff[33:32]);

   // Sign the term and clip it to 32 bits
   always_ff @(posedge clock) begin
      if (n4_ff) begin
         if (mag4_ff > 62'h8000_0000) begin
            term5_ff <= 32'sh8000_0000;
            tsat5_ff <= 1'b1;
         end else begin
            term5_ff <= -$signed(mag4_ff[31:0]);
            tsat5_ff <= 1'b0;
         end
      end else begin
         if (mag4_ff > 62'h7FFF_FFFF) begin
            term5_ff <= 32'sh7FFF_FFFF;
            tsat5_ff <= 1'b1;
         end else begin
            term5_ff <= $signed(mag4_ff[31:0]);
            tsat5_ff <= 1'b0;
         end
      end
   end

   // Saturating accumulation in order of the eigenpairs
   always_comb begin
      sum = 34'(acc_ff) + 34'(term5_ff);
      if (sum > 34'sh0_7FFF_FFFF) begin
         sum_clip = 32'sh7FFF_FFFF;
         sum_sat  = 1'b1;
      end else if (sum < -34'sh0_8000_0000) begin
         sum_clip = 32'sh8000_0000;
         sum_sat  = 1'b1;
      end else begin
         sum_clip = sum[31:0];
         sum_sat  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else if (v5_ff) begin
         acc_ff <= sum_clip;
         sat_ff <= sat_ff | sum_sat | tsat5_ff;
      end
   end

   // Present the result for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.zero | (v5_ff & l5_ff);
      end
      if (cmd.zero) begin
         rsp_prob_ff <= '0;
         rsp_sat_ff  <= 1'b0;
      end else begin
         rsp_prob_ff <= sum_clip;
         rsp_sat_ff  <= sat_ff | sum_sat | tsat5_ff;
      end
   end

   assign status.done     = v5_ff & l5_ff;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_probability = rsp_prob_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

@@ rtl/core/spsum_ctrl.sv @@
// Controller: takes items, issues one eigenpair per cycle, waits for the sum.
module spsum_ctrl import spsum_pkg::*; #(
   parameter int MAX_STATES = MAX_STATES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [1:0]                    req_func,
   input  logic [5:0]                    req_row_index,
   input  logic [5:0]                    req_col_index,
   input  logic [6:0]                    state_count,
   input  dp_status_type                 status,
   output logic                          busy,
   output ctrl_cmd_type                  cmd,
   output logic [$clog2(MAX_STATES)-1:0] idx
);

   localparam int AW = $clog2(MAX_STATES);
   localparam int CW = $clog2(MAX_STATES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   state_type     state_ff;
   logic [AW-1:0] idx_ff;
   logic [CW-1:0] cnt_ff, cnt_clip;
   logic          query_ok, is_query;

   // Decode the item and clip the pair count
   always_comb begin
      is_query = func_type'(req_func) == FUNC_QUERY;
      query_ok = (32'(req_row_index) < 32'(MAX_STATES))
                 && (32'(req_col_index) < 32'(MAX_STATES))
                 && (state_count != 7'd0);
      cnt_clip = (32'(state_count) > 32'(MAX_STATES)) ? CW'(MAX_STATES)
                                                       : CW'(state_count);
      cmd.write = (state_ff == ST_IDLE) && start && !is_query;
      cmd.load  = (state_ff == ST_IDLE) && start && is_query;
      cmd.zero  = cmd.load && !query_ok;
      cmd.issue = state_ff == ST_ISSUE;
      cmd.last  = cmd.issue && ((CW'(idx_ff) + CW'(1)) == cnt_ff);
   end

   // Sequence a query
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (cmd.load && query_ok) begin
                  cnt_ff   <= cnt_clip;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               idx_ff <= idx_ff + AW'(1);
               if (cmd.last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (status.done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy = state_ff != ST_IDLE;
   assign idx  = idx_ff;

endmodule
